// ===== hw/rtl/itrn_pkg.sv =====
package itrn_pkg;

    // ASCII codes of the numeral letters
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_NONE = 8'h00;

    localparam int unsigned VALUE_W    = 12;
    localparam int unsigned MAX_VALUE  = 3999;
    localparam int unsigned ITRN_QDEPTH = 2;

    // Digit places
    localparam logic [1:0] PLACE_UNITS     = 2'd0;
    localparam logic [1:0] PLACE_TENS      = 2'd1;
    localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
    localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

    // One classified request between front and back
    typedef struct packed {
        logic       err;
        logic [1:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] un;
    } itrn_entry_t;

    typedef struct packed {
        logic        push;
        itrn_entry_t entry;
    } itrn_wr_t;

    typedef struct packed {
        logic        avail;
        itrn_entry_t entry;
    } itrn_rd_t;

    function automatic logic [7:0] unit_letter(input logic [1:0] place);
        logic [7:0] r;
        case (place)
            PLACE_UNITS:    r = CH_I;
            PLACE_TENS:     r = CH_X;
            PLACE_HUNDREDS: r = CH_C;
            default:        r = CH_M;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] five_letter(input logic [1:0] place);
        logic [7:0] r;
        case (place)
            PLACE_UNITS:    r = CH_V;
            PLACE_TENS:     r = CH_L;
            PLACE_HUNDREDS: r = CH_D;
            default:        r = CH_M;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ten_letter(input logic [1:0] place);
        logic [7:0] r;
        case (place)
            PLACE_UNITS:    r = CH_X;
            PLACE_TENS:     r = CH_C;
            default:        r = CH_M;
        endcase
        return r;
    endfunction

    // Number of letters a decimal digit produces
    function automatic logic [2:0] pat_len(input logic [3:0] d);
        logic [2:0] r;
        case (d)
            4'd1:    r = 3'd1;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd2;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd2;
            4'd7:    r = 3'd3;
            4'd8:    r = 3'd4;
            4'd9:    r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Letter at position idx of digit d's pattern
    function automatic logic [7:0] pat_letter(input logic [3:0] d, input logic [1:0] idx,
                                              input logic [1:0] place);
        logic [7:0] r;
        case (d)
            4'd4:                   r = (idx == 2'd0) ? unit_letter(place) : five_letter(place);
            4'd9:                   r = (idx == 2'd0) ? unit_letter(place) : ten_letter(place);
            4'd5, 4'd6, 4'd7, 4'd8: r = (idx == 2'd0) ? five_letter(place) : unit_letter(place);
            default:                r = unit_letter(place);
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/itrn_front.sv =====
module itrn_front
    import itrn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  logic               push,
    output logic               full,
    input  logic               q_full,
    output itrn_wr_t           wr
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_TH   = 4'b0010,
        F_HU   = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [9:0]         rem_reg, rem_next;
    logic [1:0]         th_reg, th_next;
    logic [3:0]         hu_reg, hu_next;
    logic               err_reg, err_next;

    logic [1:0]  th_c;
    logic [11:0] th_base;
    logic [3:0]  hu_c;
    logic [9:0]  hu_base;
    logic [3:0]  te_c;
    logic [6:0]  te_base;

    // Thousands by compare
    always_comb
    begin
        th_c    = 2'd0;
        th_base = 12'd0;
        if (val_reg >= 12'd3000)
        begin
            th_c    = 2'd3;
            th_base = 12'd3000;
        end
        else if (val_reg >= 12'd2000)
        begin
            th_c    = 2'd2;
            th_base = 12'd2000;
        end
        else if (val_reg >= 12'd1000)
        begin
            th_c    = 2'd1;
            th_base = 12'd1000;
        end
    end

    // Hundreds and tens by parallel compares
    always_comb
    begin
        hu_c    = 4'd0;
        hu_base = 10'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg >= 10'(k * 100))
            begin
                hu_c    = 4'(k);
                hu_base = 10'(k * 100);
            end
        end
    end

    always_comb
    begin
        te_c    = 4'd0;
        te_base = 7'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg[6:0] >= 7'(k * 10))
            begin
                te_c    = 4'(k);
                te_base = 7'(k * 10);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        th_next    = th_reg;
        hu_next    = hu_reg;
        err_next   = err_reg;
        wr         = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    val_next   = value;
                    state_next = F_TH;
                end
            end
            F_TH:
            begin
                err_next = (val_reg == '0) || (val_reg > VALUE_W'(MAX_VALUE));
                th_next  = th_c;
                rem_next = 10'(val_reg - th_base);
                state_next = ((val_reg == '0) || (val_reg > VALUE_W'(MAX_VALUE))) ?
                             F_PUSH : F_HU;
            end
            F_HU:
            begin
                hu_next    = hu_c;
                rem_next   = rem_reg - hu_base;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                wr.entry.err = err_reg;
                wr.entry.th  = err_reg ? 2'd0 : th_reg;
                wr.entry.hu  = err_reg ? 4'd0 : hu_reg;
                wr.entry.te  = err_reg ? 4'd0 : te_c;
                wr.entry.un  = err_reg ? 4'd0 : 4'(rem_reg[6:0] - te_base);
                if (!q_full)
                begin
                    wr.push    = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign full = (state_reg != F_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        th_reg  <= th_next;
        hu_reg  <= hu_next;
        err_reg <= err_next;
    end

endmodule

// ===== hw/rtl/itrn_queue.sv =====
module itrn_queue
    import itrn_pkg::*;
#(
    parameter int unsigned DEPTH = ITRN_QDEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  itrn_wr_t wr,
    output logic     q_full,
    input  logic     rd_pop,
    output itrn_rd_t rd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    itrn_entry_t   mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full   = (count_reg == CW'(DEPTH));
    assign rd.avail = (count_reg != '0);
    assign rd.entry = mem_reg[rd_ptr_reg];
    assign do_wr    = wr.push && !q_full;
    assign do_rd    = rd_pop && rd.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr.entry;
        end
    end

endmodule

// ===== hw/rtl/itrn_back.sv =====
module itrn_back
    import itrn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  itrn_rd_t   rd,
    output logic       rd_pop,
    output logic [7:0] letter,
    output logic       last,
    output logic       range_error,
    output logic       empty,
    input  logic       pop
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_RUN   = 3'b010,
        B_FAULT = 3'b100
    } back_state_t;

    back_state_t     state_reg, state_next;
    logic [3:0][3:0] digits_reg, digits_next;
    logic [1:0]      rep_reg, rep_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      letter_reg, letter_next;
    logic            last_reg, last_next;
    logic            err_reg, err_next;

    logic [1:0] place;
    logic [3:0] dig;
    logic [2:0] len;
    logic       digit_done;
    logic       can_emit;
    logic       out_load;

    // Highest non-zero digit is the one being spelled
    always_comb
    begin
        if (digits_reg[3] != 4'd0)
        begin
            place = PLACE_THOUSANDS;
        end
        else if (digits_reg[2] != 4'd0)
        begin
            place = PLACE_HUNDREDS;
        end
        else if (digits_reg[1] != 4'd0)
        begin
            place = PLACE_TENS;
        end
        else
        begin
            place = PLACE_UNITS;
        end
    end

    assign dig        = digits_reg[place];
    assign len        = pat_len(dig);
    assign digit_done = ({1'b0, rep_reg} == (len - 3'd1));
    assign can_emit   = !out_valid_reg || pop;

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        rep_next    = rep_reg;
        rd_pop      = 1'b0;
        out_load    = 1'b0;
        letter_next = letter_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (rd.avail)
                begin
                    rd_pop      = 1'b1;
                    digits_next = {{2'b00, rd.entry.th}, rd.entry.hu, rd.entry.te, rd.entry.un};
                    rep_next    = 2'd0;
                    state_next  = rd.entry.err ? B_FAULT : B_RUN;
                end
            end
            B_RUN:
            begin
                if (can_emit)
                begin
                    out_load    = 1'b1;
                    letter_next = pat_letter(dig, rep_reg, place);
                    err_next    = 1'b0;
                    last_next   = 1'b0;
                    if (digit_done)
                    begin
                        digits_next[place] = 4'd0;
                        rep_next           = 2'd0;
                        if (digits_next == '0)
                        begin
                            last_next  = 1'b1;
                            state_next = B_IDLE;
                        end
                    end
                    else
                    begin
                        rep_next = rep_reg + 2'd1;
                    end
                end
            end
            B_FAULT:
            begin
                if (can_emit)
                begin
                    out_load    = 1'b1;
                    letter_next = CH_NONE;
                    last_next   = 1'b1;
                    err_next    = 1'b1;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign letter      = letter_reg;
    assign last        = last_reg;
    assign range_error = err_reg;
    assign empty       = !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            digits_reg    <= '0;
            rep_reg       <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            digits_reg    <= digits_next;
            rep_reg       <= rep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            letter_reg <= letter_next;
            last_reg   <= last_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== hw/rtl/integer_to_roman_numeral.sv =====
// Integer to Roman numeral converter.
//
// Input channel: present a 12-bit value with push; it is taken on a rising
// edge where push is high and full is low. Valid values run from 1 to 3999.
// Output channel: while empty is low, letter holds the oldest waiting ASCII
// letter (I V X L C D M), most significant first; take it with pop. last marks
// the final letter of a value. A value of 0 or above 3999 gives one request
// with letter 0, last 1 and range_error 1.
// The front splits a taken value into decimal digits through the states
// F_TH, F_HU and F_PUSH (F_HU is skipped for a value out of range), and full
// stays high from taking a value until its digits are written into the queue;
// the back loads each value from the queue and then spells one letter per
// cycle while the receiver keeps taking them. A queue of QUEUE_DEPTH split
// values lets the front run ahead while the back is spelling.
// When the receiver stalls, the current letter holds on the ports, the back
// waits, the queue fills and then full holds off further requests.
// Reset (rst_n low, asynchronous) drops everything in flight: empty goes
// high and full goes low.
module integer_to_roman_numeral
    import itrn_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = ITRN_QDEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [VALUE_W-1:0] value,
    input  logic               push,
    output logic               full,
    output logic [7:0]         letter,
    output logic               last,
    output logic               range_error,
    output logic               empty,
    input  logic               pop
);

    itrn_wr_t wr;
    itrn_rd_t rd;
    logic     q_full;
    logic     rd_pop;

    // Accept and split the value into decimal digits
    itrn_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .push   (push),
        .full   (full),
        .q_full (q_full),
        .wr     (wr)
    );

    // Hold split values between front and back
    itrn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .q_full (q_full),
        .rd_pop (rd_pop),
        .rd     (rd)
    );

    // Spell the digits one letter per cycle, while the receiver keeps up, into the output register
    itrn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd          (rd),
        .rd_pop      (rd_pop),
        .letter      (letter),
        .last        (last),
        .range_error (range_error),
        .empty       (empty),
        .pop         (pop)
    );

endmodule

// ===== hw/rtl/itrn_checker.sv =====
module itrn_checker
    import itrn_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic [7:0]         letter,
    input logic               last,
    input logic               range_error,
    input logic               empty,
    input logic               pop
);

    // An error request is a lone, letterless final request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && range_error) |-> (last && letter == CH_NONE))
        else $error("error request not marked last or carries a letter");

    // Any other request carries a numeral letter
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !range_error) |->
            (letter == CH_I || letter == CH_V || letter == CH_X || letter == CH_L ||
             letter == CH_C || letter == CH_D || letter == CH_M))
        else $error("letter outside numeral alphabet");

    // A stalled request stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(letter) && $stable(last) &&
                              $stable(range_error)))
        else $error("stalled request changed");

    // The front holds off new values right after taking one
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("value taken while previous still splitting");

endmodule

bind integer_to_roman_numeral itrn_checker u_itrn_checker (.*);

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itrn_pkg::*;

    // One letter of a numeral as it leaves the block
    typedef struct packed {
        logic [7:0] letter;
        logic       last;
        logic       range_error;
    } numeral_letter_t;

    // Cycles with no request moving on either side before the run is abandoned.
    // The longest correct quiet stretch is the deliberate receiver hold-off below.
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned SETTLE_CYCLES  = 40;
    localparam int unsigned RANDOM_VALUES  = 440;

    logic               clk;
    logic               rst_n;
    logic [VALUE_W-1:0] value;
    logic               push;
    logic               full;
    logic [7:0]         letter;
    logic               last;
    logic               range_error;
    logic               empty;
    logic               pop;

    // Letters still owed by the block, oldest first
    numeral_letter_t pending_letters [$];
    int unsigned     letter_faults;
    // Set by a test to make the receiver hold off; the receiver counts it down
    int unsigned     hold_off_left;

    integer_to_roman_numeral dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .push        (push),
        .full        (full),
        .letter      (letter),
        .last        (last),
        .range_error (range_error),
        .empty       (empty),
        .pop         (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Spell one value into the letters the block must produce for it.
    // Zero and anything above the largest numeral give a single error letter.
    function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
        logic [7:0]      one_mark [4];
        logic [7:0]      five_mark [4];
        logic [7:0]      ten_mark [4];
        int unsigned     digit [4];
        logic [7:0]      lead;
        logic [7:0]      tail;
        int unsigned     reps;
        numeral_letter_t item;
        one_mark  = '{CH_I, CH_X, CH_C, CH_M};
        five_mark = '{CH_V, CH_L, CH_D, CH_M};
        ten_mark  = '{CH_X, CH_C, CH_M, CH_M};
        item.last        = 1'b0;
        item.range_error = 1'b0;
        if (v == '0 || v > MAX_VALUE)
        begin
            item.letter      = CH_NONE;
            item.last        = 1'b1;
            item.range_error = 1'b1;
            pending_letters.push_back(item);
            return;
        end
        digit[PLACE_THOUSANDS] = v / 1000;
        digit[PLACE_HUNDREDS]  = (v / 100) % 10;
        digit[PLACE_TENS]      = (v / 10) % 10;
        digit[PLACE_UNITS]     = v % 10;
        // Most significant place first; a zero digit adds nothing
        for (int p = 3; p >= 0; p--)
        begin
            lead = CH_NONE;
            tail = CH_NONE;
            reps = 0;
            case (digit[p])
                1, 2, 3:    reps = digit[p];
                4:
                begin
                    lead = one_mark[p];
                    tail = five_mark[p];
                end
                9:
                begin
                    lead = one_mark[p];
                    tail = ten_mark[p];
                end
                5, 6, 7, 8:
                begin
                    lead = five_mark[p];
                    reps = digit[p] - 5;
                end
                default: ;
            endcase
            if (lead != CH_NONE)
            begin
                item.letter = lead;
                pending_letters.push_back(item);
            end
            if (tail != CH_NONE)
            begin
                item.letter = tail;
                pending_letters.push_back(item);
            end
            for (int r = 0; r < reps; r++)
            begin
                item.letter = one_mark[p];
                pending_letters.push_back(item);
            end
        end
        // A valid value always yields at least one letter; flag the final one
        pending_letters[pending_letters.size() - 1].last = 1'b1;
    endfunction

    // Offer one value and hold it until the block takes the request.
    // Push is left high so that back-to-back requests need no gap.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        @(negedge clk);
        value = v;
        push  = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (full);
        spell_numeral(v);
    endtask

    // Drop push for a number of cycles; scramble the idle value meanwhile
    task automatic idle_sender(input int unsigned cycles);
        @(negedge clk);
        push  = 1'b0;
        value = VALUE_W'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_letters.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly valid values, a few out of range, and a share of short numerals
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        else if (roll < 10)
            return VALUE_W'($urandom_range(4095, MAX_VALUE + 1));
        else if (roll < 25)
            return VALUE_W'($urandom_range(99, 1));
        else
            return VALUE_W'($urandom_range(MAX_VALUE, 1));
    endfunction

    // Edges of the range, digit patterns at each place, the longest
    // numeral and the out-of-range cases, including all input bits set
    task automatic test_directed();
        logic [VALUE_W-1:0] picks [$];
        picks = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd4,
                  12'd9, 12'd5, 12'd8, 12'd40, 12'd90, 12'd400, 12'd900,
                  12'd1000, 12'd2000, 12'd3000, 12'd1994, 12'd444, 12'd999,
                  12'd2730, 12'd1365, 12'd2048, 12'd3, 12'd7};
        foreach (picks[i])
        begin
            send_value(picks[i]);
            if ($urandom_range(3) == 0)
                idle_sender($urandom_range(6, 1));
        end
        idle_sender(1);
    endtask

    // Hold the receiver off while requests keep coming, so the internal
    // queue fills and full stalls the sender
    task automatic test_full_queue();
        @(posedge clk);
        hold_off_left = LONG_HOLD;
        for (int i = 0; i < 16; i++)
        begin
            send_value(VALUE_W'($urandom_range(MAX_VALUE, 1)));
        end
        idle_sender(1);
    endtask

    // Stop sending until every owed letter has come out, then resume
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++)
        begin
            send_value(pick_value());
        end
        idle_sender(1);
        wait_drained();
        for (int i = 0; i < 10; i++)
        begin
            send_value(pick_value());
        end
        idle_sender(1);
    endtask

    // Bursts of random length with random gaps; some gaps are zero so that
    // long runs of back-to-back requests occur
    task automatic test_random_bursts();
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < RANDOM_VALUES)
        begin
            burst = $urandom_range(24, 1);
            for (int i = 0; i < burst && sent < RANDOM_VALUES; i++)
            begin
                send_value(pick_value());
                sent++;
            end
            if ($urandom_range(2) != 0)
                idle_sender($urandom_range(30, 1));
        end
        idle_sender(1);
    endtask

    // Receiver: switch between stall patterns of random length; a pending
    // hold-off overrides the pattern and is counted down here
    initial
    begin : receiver
        int unsigned mode;
        int unsigned mode_left;
        pop       = 1'b0;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left != 0)
            begin
                pop = 1'b0;
                hold_off_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(3);
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                case (mode)
                    0:       pop = 1'b1;
                    1:       pop = ($urandom_range(1) == 0);
                    2:       pop = ($urandom_range(3) == 0);
                    default: pop = (mode_left % 8) < 5;
                endcase
            end
        end
    end

    // Compare every accepted letter with the oldest one owed
    always @(posedge clk)
    begin : check_letter
        numeral_letter_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_letters.size() == 0)
            begin
                $display("%0t: letter expected none actual %h last %b range_error %b",
                         $time, letter, last, range_error);
                letter_faults++;
            end
            else
            begin
                want = pending_letters.pop_front();
                if (letter !== want.letter)
                begin
                    $display("%0t: letter expected %h actual %h", $time, want.letter, letter);
                    letter_faults++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                    letter_faults++;
                end
                if (range_error !== want.range_error)
                begin
                    $display("%0t: range_error expected %b actual %b",
                             $time, want.range_error, range_error);
                    letter_faults++;
                end
            end
        end
    end

    // Abandon the run once no request has moved for too long
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        value         = '0;
        letter_faults = 0;
        hold_off_left = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_queue();
        test_drain_pause();
        test_random_bursts();

        // Let the last letters out, then allow for anything stray
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (letter_faults == 0 && pending_letters.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
